### rtl/core/tlaik_pkg.sv
// shared widths, types, constants and helpers for the two-link arm inverse kinematics core
`timescale 1ns / 1ps

package tlaik_pkg;

    // field widths
    localparam int POS_W     = 24;
    localparam int ANG_W     = 16;
    localparam int LEN_W     = 22;
    localparam int CFG_IDX_W = 2;

    // stream word layout
    localparam int S_DATA_W = 3 * POS_W + ANG_W;
    localparam int M_DATA_W = 3 * ANG_W + POS_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINK1 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LINK2 = CFG_IDX_W'(1);

    // datapath widths
    localparam int XSQ_W    = 2 * POS_W - 1;
    localparam int RSQ_W    = XSQ_W + 1;
    localparam int SQ_W     = 2 * LEN_W;
    localparam int RMAX_W   = 2 * (LEN_W + 1);
    localparam int DEN_W    = SQ_W + 1;
    localparam int NUM_W    = RSQ_W + 2;
    localparam int QUO_BITS = 30;
    localparam int COS_W    = QUO_BITS + 2;
    localparam int RAD_W    = 2 * QUO_BITS + 1;
    localparam int ROOT_W   = QUO_BITS + 1;
    localparam int PK_W     = LEN_W + 1 + COS_W;
    localparam int AT_IN_W  = 56;
    localparam int AT_W     = AT_IN_W + 2;
    localparam int ZW       = 32;

    // atan2 normalisation: magnitude brought into [2^NORM_TOP, 2^(NORM_TOP+1))
    localparam int NORM_STEPS = 6;
    localparam int NORM_TOP   = 53;

    localparam logic [ZW-1:0] HALF_TURN = ZW'(1) << (ZW - 1);
    localparam logic [ZW-1:0] ROUND_ADD = ZW'(1) << (ZW - ANG_W - 1);

    localparam int ATAN_TAB_LEN      = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [ZW-1:0] ATAN_TAB [ATAN_TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // per-item side data carried alongside the arithmetic units
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [POS_W-1:0]        z;
        logic [ANG_W-1:0]        phi;
        logic                    left;
        logic                    reach;
        logic                    neg;
        logic                    sat;
        logic signed [COS_W-1:0] c;
        logic signed [COS_W-1:0] s;
    } side_t;

    // 32-bit binary angle to 16 bits, round half up
    function automatic logic [ANG_W-1:0] round_angle(input logic [ZW-1:0] a);
        logic [ZW-1:0] sum;
        sum = a + ROUND_ADD;
        return sum[ZW-1:ZW-ANG_W];
    endfunction

endpackage

### rtl/core/tlaik_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module tlaik_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [tlaik_pkg::DEN_W-1:0]    dividend,
    input  logic [tlaik_pkg::DEN_W-1:0]    divisor,
    output logic                          out_valid,
    output logic [tlaik_pkg::QUO_BITS-1:0] quotient
);
    import tlaik_pkg::*;

    logic [QUO_BITS-1:0] vld_reg;
    logic [DEN_W-1:0]    rem_reg  [QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg  [QUO_BITS];
    logic [DEN_W-1:0]    rem_in   [QUO_BITS];
    logic [QUO_BITS-1:0] quo_in   [QUO_BITS];
    logic [DEN_W-1:0]    rem_next [QUO_BITS];
    logic [QUO_BITS-1:0] quo_next [QUO_BITS];
    logic [DEN_W:0]      rem_sh;
    logic [DEN_W:0]      dsr;
    logic                ge;

    always_comb begin
        dsr       = {1'b0, divisor};
        rem_in[0] = dividend;
        quo_in[0] = '0;
        for (int i = 1; i < QUO_BITS; i++) begin
            rem_in[i] = rem_reg[i-1];
            quo_in[i] = quo_reg[i-1];
        end
        for (int i = 0; i < QUO_BITS; i++) begin
            rem_sh      = {rem_in[i], 1'b0};
            ge          = (rem_sh >= dsr);
            rem_next[i] = ge ? DEN_W'(rem_sh - dsr) : rem_sh[DEN_W-1:0];
            quo_next[i] = {quo_in[i][QUO_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QUO_BITS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < QUO_BITS; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign out_valid = vld_reg[QUO_BITS-1];
    assign quotient  = quo_reg[QUO_BITS-1];

endmodule

### rtl/core/tlaik_isqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module tlaik_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tlaik_pkg::RAD_W-1:0]  radicand,
    output logic                        out_valid,
    output logic [tlaik_pkg::ROOT_W-1:0] root
);
    import tlaik_pkg::*;

    localparam int PAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [ROOT_W-1:0] vld_reg;
    logic [PAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [PAD_W-1:0]  rad_in    [ROOT_W];
    logic [REM_W-1:0]  rem_in    [ROOT_W];
    logic [ROOT_W-1:0] root_in   [ROOT_W];
    logic [PAD_W-1:0]  rad_next  [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              ge;

    always_comb begin
        rad_in[0]  = PAD_W'(radicand);
        rem_in[0]  = '0;
        root_in[0] = '0;
        for (int i = 1; i < ROOT_W; i++) begin
            rad_in[i]  = rad_reg[i-1];
            rem_in[i]  = rem_reg[i-1];
            root_in[i] = root_reg[i-1];
        end
        for (int i = 0; i < ROOT_W; i++) begin
            cur          = {rem_in[i], rad_in[i][PAD_W-1:PAD_W-2]};
            trial        = (REM_W+2)'({root_in[i], 2'b01});
            ge           = (cur >= trial);
            rem_next[i]  = ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
            root_next[i] = {root_in[i][ROOT_W-2:0], ge};
            rad_next[i]  = {rad_in[i][PAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < ROOT_W; i++) begin
                rad_reg[i]  <= rad_next[i];
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];

endmodule

### rtl/core/tlaik_atan2.sv
// pipelined atan2: normalising shifter, half-turn fold and vectoring cordic
`timescale 1ns / 1ps

module tlaik_atan2 #(
    parameter int STAGES = tlaik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [tlaik_pkg::AT_IN_W-1:0] y_in,
    input  logic signed [tlaik_pkg::AT_IN_W-1:0] x_in,
    output logic                               out_valid,
    output logic [tlaik_pkg::ZW-1:0]            angle
);
    import tlaik_pkg::*;

    localparam int LAT = NORM_STEPS + 1 + STAGES;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] zero_reg;

    logic signed [AT_W-1:0] nx_reg  [NORM_STEPS];
    logic signed [AT_W-1:0] ny_reg  [NORM_STEPS];
    logic signed [AT_W-1:0] nx_in   [NORM_STEPS];
    logic signed [AT_W-1:0] ny_in   [NORM_STEPS];
    logic signed [AT_W-1:0] nx_next [NORM_STEPS];
    logic signed [AT_W-1:0] ny_next [NORM_STEPS];

    logic signed [AT_W-1:0] fx_reg, fy_reg, fx_next, fy_next;
    logic [ZW-1:0]          fz_reg, fz_next;

    logic signed [AT_W-1:0] cx_reg  [STAGES];
    logic signed [AT_W-1:0] cy_reg  [STAGES];
    logic [ZW-1:0]          cz_reg  [STAGES];
    logic signed [AT_W-1:0] cx_in   [STAGES];
    logic signed [AT_W-1:0] cy_in   [STAGES];
    logic [ZW-1:0]          cz_in   [STAGES];
    logic signed [AT_W-1:0] cx_next [STAGES];
    logic signed [AT_W-1:0] cy_next [STAGES];
    logic [ZW-1:0]          cz_next [STAGES];

    logic signed [AT_W-1:0] lim;
    logic signed [AT_W-1:0] xs, ys;
    logic                   fits;
    logic                   zero_in;
    int                     sh;

    assign zero_in = (x_in == '0) && (y_in == '0);

    always_comb begin
        // normalisation, largest shift first
        nx_in[0] = AT_W'(x_in);
        ny_in[0] = AT_W'(y_in);
        for (int i = 1; i < NORM_STEPS; i++) begin
            nx_in[i] = nx_reg[i-1];
            ny_in[i] = ny_reg[i-1];
        end
        for (int i = 0; i < NORM_STEPS; i++) begin
            sh   = (1 << (NORM_STEPS - 1)) >> i;
            lim  = AT_W'(1) <<< (NORM_TOP + 1 - sh);
            fits = (nx_in[i] < lim) && (nx_in[i] > -lim) &&
                   (ny_in[i] < lim) && (ny_in[i] > -lim);
            nx_next[i] = fits ? (nx_in[i] <<< sh) : nx_in[i];
            ny_next[i] = fits ? (ny_in[i] <<< sh) : ny_in[i];
        end

        // fold the left half plane by a half turn
        if (nx_reg[NORM_STEPS-1] < 0) begin
            fx_next = -nx_reg[NORM_STEPS-1];
            fy_next = -ny_reg[NORM_STEPS-1];
            fz_next = HALF_TURN;
        end else begin
            fx_next = nx_reg[NORM_STEPS-1];
            fy_next = ny_reg[NORM_STEPS-1];
            fz_next = '0;
        end

        // vectoring iterations
        cx_in[0] = fx_reg;
        cy_in[0] = fy_reg;
        cz_in[0] = fz_reg;
        for (int i = 1; i < STAGES; i++) begin
            cx_in[i] = cx_reg[i-1];
            cy_in[i] = cy_reg[i-1];
            cz_in[i] = cz_reg[i-1];
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = cx_in[i] >>> i;
            ys = cy_in[i] >>> i;
            if (cy_in[i] >= 0) begin
                cx_next[i] = cx_in[i] + ys;
                cy_next[i] = cy_in[i] - xs;
                cz_next[i] = cz_in[i] + ATAN_TAB[i];
            end else begin
                cx_next[i] = cx_in[i] - ys;
                cy_next[i] = cy_in[i] + xs;
                cz_next[i] = cz_in[i] - ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= {zero_reg[LAT-2:0], zero_in};
            for (int i = 0; i < NORM_STEPS; i++) begin
                nx_reg[i] <= nx_next[i];
                ny_reg[i] <= ny_next[i];
            end
            fx_reg <= fx_next;
            fy_reg <= fy_next;
            fz_reg <= fz_next;
            for (int i = 0; i < STAGES; i++) begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign angle     = zero_reg[LAT-1] ? '0 : cz_reg[STAGES-1];

endmodule

### rtl/core/two_link_arm_inverse_kinematics_top.sv
// two-link planar arm inverse kinematics core, fully pipelined stream top level
// pipeline: a word passes through 80 + CORDIC_STAGES
//   registers (4 front stages, 30 divider, 3 cosine/sine prep, 31 square root, 3 k1/k2,
//   7 + CORDIC_STAGES atan2, 1 angle combine, 1 output register)
// throughput: one word per cycle while the skid slot is empty; the depth is set by the divider, root and cordic chains
// reset: aresetn synchronous active low, clears the valid bits and both link lengths to zero
`timescale 1ns / 1ps

module two_link_arm_inverse_kinematics_top #(
    parameter int CORDIC_STAGES = tlaik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // target stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // target_x, target_y, target_z, tool angle from bit 0 up
    input  logic [tlaik_pkg::S_DATA_W-1:0]     s_tdata,
    // elbow_left
    input  logic                              s_tuser,
    // joint stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // shoulder_angle, elbow_angle, lift_position, wrist_angle from bit 0 up
    output logic [tlaik_pkg::M_DATA_W-1:0]     m_tdata,
    // reachable
    output logic                              m_tuser,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlaik_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlaik_pkg::LEN_W-1:0]        cfg_data
);
    import tlaik_pkg::*;

    localparam int ATAN_LAT = NORM_STEPS + 1 + CORDIC_STAGES;

    // the whole pipe moves together; it halts only while the skid slot holds a word
    logic en;

    // ------------------------------------------------------------------
    // link lengths and products derived from them
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  l1_reg, l2_reg;
    logic [SQ_W-1:0]   l1sq_reg, l2sq_reg, rminsq_reg;
    logic [RMAX_W-1:0] rmaxsq_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              links_ok_reg;
    logic [LEN_W:0]    lsum, ldiff;
    logic [SQ_W-1:0]   l1l2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg <= '0;
            l2_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LINK1: l1_reg <= cfg_data;
                REG_LINK2: l2_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign lsum  = (LEN_W+1)'(l1_reg) + (LEN_W+1)'(l2_reg);
    assign ldiff = (l1_reg > l2_reg) ? (LEN_W+1)'(l1_reg - l2_reg)
                                     : (LEN_W+1)'(l2_reg - l1_reg);
    assign l1l2  = SQ_W'(l1_reg) * SQ_W'(l2_reg);

    // refreshed every cycle from the link length registers, so a register write reaches them one register later
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1sq_reg     <= '0;
            l2sq_reg     <= '0;
            rminsq_reg   <= '0;
            rmaxsq_reg   <= '0;
            den_reg      <= '0;
            links_ok_reg <= 1'b0;
        end else begin
            l1sq_reg     <= SQ_W'(l1_reg) * SQ_W'(l1_reg);
            l2sq_reg     <= SQ_W'(l2_reg) * SQ_W'(l2_reg);
            rminsq_reg   <= SQ_W'(ldiff[LEN_W-1:0]) * SQ_W'(ldiff[LEN_W-1:0]);
            rmaxsq_reg   <= RMAX_W'(lsum) * RMAX_W'(lsum);
            den_reg      <= {l1l2, 1'b0};
            links_ok_reg <= (l1_reg != '0) && (l2_reg != '0);
        end
    end

    // ------------------------------------------------------------------
    // stage 1: unpack the word and square the target coordinates
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0]   in_x, in_y;
    logic signed [2*POS_W-1:0] xx_full, yy_full;
    side_t                     sd_in;
    logic                      v1_reg;
    side_t                     sd1_reg;
    logic [XSQ_W-1:0]          xx1_reg, yy1_reg;

    assign in_x    = s_tdata[POS_W-1:0];
    assign in_y    = s_tdata[2*POS_W-1:POS_W];
    assign xx_full = in_x * in_x;
    assign yy_full = in_y * in_y;

    always_comb begin
        sd_in       = '0;
        sd_in.x     = in_x;
        sd_in.y     = in_y;
        sd_in.z     = s_tdata[3*POS_W-1:2*POS_W];
        sd_in.phi   = s_tdata[3*POS_W+ANG_W-1:3*POS_W];
        sd_in.left  = s_tuser;
    end

    // ------------------------------------------------------------------
    // stage 2: squared radius
    // stage 3: workspace annulus test and law of cosines numerator
    // stage 4: magnitude against denominator, cosine saturation
    // ------------------------------------------------------------------
    logic                    v2_reg, v3_reg, v4_reg;
    side_t                   sd2_reg, sd3_reg, sd4_reg;
    logic [RSQ_W-1:0]        rsq2_reg;
    logic signed [NUM_W-1:0] num3_reg;
    logic [DEN_W-1:0]        mag4_reg;
    logic [NUM_W-2:0]        mag;
    side_t                   sd3_next, sd4_next;
    logic signed [NUM_W-1:0] num_next;

    always_comb begin
        sd3_next       = sd2_reg;
        sd3_next.reach = links_ok_reg &&
                         (rsq2_reg <= RSQ_W'(rmaxsq_reg)) &&
                         (rsq2_reg >= RSQ_W'(rminsq_reg));
        num_next       = NUM_W'(rsq2_reg) - NUM_W'(l1sq_reg) - NUM_W'(l2sq_reg);

        mag          = (num3_reg < 0) ? (NUM_W-1)'(-num3_reg) : num3_reg[NUM_W-2:0];
        sd4_next     = sd3_reg;
        sd4_next.neg = (num3_reg < 0);
        sd4_next.sat = ((NUM_W-1)'(den_reg) <= mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd1_reg  <= sd_in;
            xx1_reg  <= xx_full[XSQ_W-1:0];
            yy1_reg  <= yy_full[XSQ_W-1:0];
            sd2_reg  <= sd1_reg;
            rsq2_reg <= RSQ_W'(xx1_reg) + RSQ_W'(yy1_reg);
            sd3_reg  <= sd3_next;
            num3_reg <= num_next;
            sd4_reg  <= sd4_next;
            mag4_reg <= mag[DEN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // cosine quotient, |num| / den as a Q30 fraction
    // ------------------------------------------------------------------
    logic                v_div;
    logic [QUO_BITS-1:0] quo;
    side_t               dsd_reg [QUO_BITS];

    tlaik_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .dividend  (mag4_reg),
        .divisor   (den_reg),
        .out_valid (v_div),
        .quotient  (quo)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            dsd_reg[0] <= sd4_reg;
            for (int i = 1; i < QUO_BITS; i++) begin
                dsd_reg[i] <= dsd_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 5: signed cosine, stage 6: its square, stage 7: 1 - cos^2
    // ------------------------------------------------------------------
    logic                    v5_reg, v6_reg, v7_reg;
    side_t                   sd5_reg, sd6_reg, sd7_reg;
    side_t                   sd5_next;
    logic [COS_W-2:0]        cmag;
    logic signed [2*COS_W-1:0] csq_full;
    logic [RAD_W-1:0]        csq6_reg, rad7_reg;

    // saturated cosine magnitude
    function automatic logic [COS_W-2:0] sd4_sat_mag(input logic sat,
                                                     input logic [QUO_BITS-1:0] q);
        return sat ? ((COS_W-1)'(1) << QUO_BITS) : (COS_W-1)'(q);
    endfunction

    always_comb begin
        cmag       = sd4_sat_mag(dsd_reg[QUO_BITS-1].sat, quo);
        sd5_next   = dsd_reg[QUO_BITS-1];
        sd5_next.c = dsd_reg[QUO_BITS-1].neg ? -COS_W'(cmag) : COS_W'(cmag);
        csq_full   = sd5_reg.c * sd5_reg.c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v_div;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd5_reg  <= sd5_next;
            sd6_reg  <= sd5_reg;
            csq6_reg <= csq_full[RAD_W-1:0];
            sd7_reg  <= sd6_reg;
            rad7_reg <= (RAD_W'(1) << (2 * QUO_BITS)) - csq6_reg;
        end
    end

    // ------------------------------------------------------------------
    // sine magnitude, floor square root
    // ------------------------------------------------------------------
    logic              v_sqrt;
    logic [ROOT_W-1:0] root;
    side_t             isd_reg [ROOT_W];

    tlaik_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .radicand  (rad7_reg),
        .out_valid (v_sqrt),
        .root      (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            isd_reg[0] <= sd7_reg;
            for (int i = 1; i < ROOT_W; i++) begin
                isd_reg[i] <= isd_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 8: elbow side sign, stage 9: l2*cos and l2*sin,
    // stage 10: k1 = l1 + l2*cos in Q30
    // ------------------------------------------------------------------
    logic                    v8_reg, v9_reg, v10_reg;
    side_t                   sd8_reg, sd9_reg, sd10_reg;
    side_t                   sd8_next;
    logic signed [LEN_W:0]   l2_s;
    logic signed [PK_W-1:0]  pk9_reg, k2_9_reg;
    logic signed [AT_IN_W-1:0] k1_10_reg, k2_10_reg;

    assign l2_s = {1'b0, l2_reg};

    always_comb begin
        sd8_next   = isd_reg[ROOT_W-1];
        sd8_next.s = isd_reg[ROOT_W-1].left ? -COS_W'(root) : COS_W'(root);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (en) begin
            v8_reg  <= v_sqrt;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd8_reg   <= sd8_next;
            sd9_reg   <= sd8_reg;
            pk9_reg   <= l2_s * sd8_reg.c;
            k2_9_reg  <= l2_s * sd8_reg.s;
            sd10_reg  <= sd9_reg;
            k1_10_reg <= AT_IN_W'({l1_reg, {QUO_BITS{1'b0}}}) + AT_IN_W'(pk9_reg);
            k2_10_reg <= AT_IN_W'(k2_9_reg);
        end
    end

    // ------------------------------------------------------------------
    // three atan2 units in lockstep: target bearing, elbow angle, offset
    // ------------------------------------------------------------------
    logic          v_at_yx, v_at_sc, v_at_k;
    logic [ZW-1:0] a_yx, a_sc, a_k;
    side_t         asd_reg [ATAN_LAT];

    tlaik_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_target (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v10_reg),
        .y_in      (AT_IN_W'(sd10_reg.y)),
        .x_in      (AT_IN_W'(sd10_reg.x)),
        .out_valid (v_at_yx),
        .angle     (a_yx)
    );

    tlaik_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_elbow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v10_reg),
        .y_in      (AT_IN_W'(sd10_reg.s)),
        .x_in      (AT_IN_W'(sd10_reg.c)),
        .out_valid (v_at_sc),
        .angle     (a_sc)
    );

    tlaik_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_offset (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v10_reg),
        .y_in      (k2_10_reg),
        .x_in      (k1_10_reg),
        .out_valid (v_at_k),
        .angle     (a_k)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            asd_reg[0] <= sd10_reg;
            for (int i = 1; i < ATAN_LAT; i++) begin
                asd_reg[i] <= asd_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 11: round to 16-bit angles, wrist = phi - shoulder - elbow
    // ------------------------------------------------------------------
    logic                fv_reg;
    logic [M_DATA_W-1:0] fdata_reg;
    logic                fuser_reg;
    logic [ANG_W-1:0]    sh_ang, el_ang, wr_ang;
    logic                at_valid;
    side_t               sd_fin;

    assign at_valid = v_at_yx && v_at_sc && v_at_k;
    assign sd_fin   = asd_reg[ATAN_LAT-1];
    assign sh_ang   = round_angle(a_yx - a_k);
    assign el_ang   = round_angle(a_sc);
    assign wr_ang   = sd_fin.phi - sh_ang - el_ang;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (en) begin
            fv_reg <= at_valid;
        end
    end

    // unreachable targets give an all-zero word
    always_ff @(posedge aclk) begin
        if (en) begin
            fdata_reg <= sd_fin.reach ? {wr_ang, sd_fin.z, el_ang, sh_ang} : '0;
            fuser_reg <= sd_fin.reach;
        end
    end

    // ------------------------------------------------------------------
    // output register with a one-word skid slot behind it
    // ------------------------------------------------------------------
    logic                skid_v_reg;
    logic [M_DATA_W-1:0] skid_data_reg, out_data_reg;
    logic                skid_user_reg, out_user_reg, out_v_reg;
    logic                pop;

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign pop      = out_v_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (pop) begin
                skid_v_reg <= 1'b0;
            end
        end else if (!out_v_reg || pop) begin
            out_v_reg <= fv_reg;
        end else if (fv_reg) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (!out_v_reg || pop) begin
            out_data_reg <= fdata_reg;
            out_user_reg <= fuser_reg;
        end else begin
            skid_data_reg <= fdata_reg;
            skid_user_reg <= fuser_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
